// ===== src/reb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reb_pkg: shared definitions for the rotary encoder and button decoder
// Field widths, configuration register indexes, reset values and step codes.
// ----------------------------------------------------------------------------
package reb_pkg;

  // Width of the saturating hold counter (legal range 8..32)
  localparam int unsigned HoldCountBits = 16;

  localparam int unsigned DebWidth   = 8;
  localparam int unsigned LongWidth  = 16;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 16;

  // Compare width that covers both the hold count and the long-press limit
  localparam int unsigned CmpWidth = (HoldCountBits > LongWidth) ? HoldCountBits : LongWidth;

  localparam logic [DebWidth-1:0]  DebounceReset  = 8'd40;
  localparam logic [LongWidth-1:0] LongPressReset = 16'd1000;

  localparam logic [CfgIdxW-1:0] RegDebounceTicks  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegLongPressTicks = 8'd1;

  localparam logic signed [1:0] StepNone = 2'sb00;
  localparam logic signed [1:0] StepUp   = 2'sb01;
  localparam logic signed [1:0] StepDown = 2'sb11;

endpackage : reb_pkg
`default_nettype wire

// ===== src/reb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reb_if: handshake channels of the encoder and button decoder
// Sample input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface reb_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic switch_level;

  modport source (output valid, output pin_a, output pin_b, output switch_level,
                  input ready);
  modport sink   (input valid, input pin_a, input pin_b, input switch_level,
                  output ready);
endinterface : reb_in_if

interface reb_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] move_step;
  logic              short_press;
  logic              long_press;
  logic              button_held;

  modport source (output valid, output move_step, output short_press,
                  output long_press, output button_held, input ready);
  modport sink   (input valid, input move_step, input short_press,
                  input long_press, input button_held, output ready);
endinterface : reb_out_if

interface reb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [reb_pkg::CfgIdxW-1:0]   index;
  logic [reb_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : reb_cfg_if
`default_nettype wire

// ===== src/rotary_encoder_button_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder: quadrature tracker and debounced push button
// One pin sample in, one result out: detent step, short/long press pulses,
// and the debounced held level.
// ----------------------------------------------------------------------------
// Each accepted sample's result is loaded straight into the output register.
// Throughput: one sample per cycle unless the output stalls; the next-state logic
// of both trackers is a single combinational pass between the state registers and
// the result register. Input is taken whenever the result register is empty or
// being drained. Reset: trackers idle, counts cleared, result register empty,
// debounce threshold 40 and long-press threshold 1000.
module rotary_encoder_button_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  reb_in_if.sink    in_i,
  reb_out_if.source out_o,
  reb_cfg_if.sink   cfg_i
);
  import reb_pkg::*;

  typedef enum logic [3:0] {
    QP_IDLE   = 4'd0,
    QP_DETENT = 4'd1,
    QP_P1     = 4'd2,
    QP_P2     = 4'd3,
    QP_P3     = 4'd4,
    QP_PDONE  = 4'd5,
    QP_M1     = 4'd6,
    QP_M2     = 4'd7,
    QP_M3     = 4'd8,
    QP_MDONE  = 4'd9
  } quad_e;

  typedef enum logic [1:0] {
    BP_IDLE    = 2'd0,
    BP_DEBPRS  = 2'd1,
    BP_PRESSED = 2'd2,
    BP_DEBREL  = 2'd3
  } btn_e;

  localparam logic [1:0] Lv00 = 2'b00;
  localparam logic [1:0] Lv01 = 2'b01;
  localparam logic [1:0] Lv10 = 2'b10;
  localparam logic [1:0] Lv11 = 2'b11;

  logic [DebWidth-1:0]      deb_ticks_q;
  logic [LongWidth-1:0]     long_ticks_q;

  quad_e                    quad_q, quad_d;
  btn_e                     btn_q, btn_d;
  logic [DebWidth-1:0]      deb_cnt_q, deb_cnt_d;
  logic [HoldCountBits-1:0] held_q, held_d;
  logic                     held_flag_q, held_flag_d;
  logic                     long_sent_q, long_sent_d;

  logic                     out_valid_q;
  logic signed [1:0]        step_q, step_d;
  logic                     short_q, short_d;
  logic                     long_q, long_d;
  logic                     held_out_q;

  logic                     in_fire;
  logic [1:0]               lv;
  logic [DebWidth-1:0]      deb_inc;
  logic [CmpWidth-1:0]      held_ext_q, held_ext_d, long_ext;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign lv         = {in_i.pin_a, in_i.pin_b};
  assign deb_inc    = deb_cnt_q + 1'b1;
  assign held_ext_q = CmpWidth'(held_q);
  assign held_ext_d = CmpWidth'(held_d);
  assign long_ext   = CmpWidth'(long_ticks_q);

  // Quadrature tracker
  always_comb begin
    quad_d = quad_q;
    step_d = StepNone;
    unique case (quad_q)
      QP_DETENT: begin
        if (lv == Lv00)      quad_d = QP_IDLE;
        else if (lv == Lv01) quad_d = QP_P1;
        else if (lv == Lv10) quad_d = QP_M1;
      end
      QP_P1: begin
        if (lv == Lv00)      quad_d = QP_P2;
        else if (lv == Lv10) quad_d = QP_IDLE;
        else if (lv == Lv11) quad_d = QP_DETENT;
      end
      QP_M1: begin
        if (lv == Lv00)      quad_d = QP_M2;
        else if (lv == Lv01) quad_d = QP_IDLE;
        else if (lv == Lv11) quad_d = QP_DETENT;
      end
      QP_P2: begin
        if (lv == Lv10)      quad_d = QP_P3;
        else if (lv == Lv11) quad_d = QP_DETENT;
      end
      QP_M2: begin
        if (lv == Lv01)      quad_d = QP_M3;
        else if (lv == Lv11) quad_d = QP_DETENT;
      end
      QP_P3: begin
        if (lv == Lv01)      quad_d = QP_IDLE;
        else if (lv == Lv11) quad_d = QP_PDONE;
      end
      QP_M3: begin
        if (lv == Lv10)      quad_d = QP_IDLE;
        else if (lv == Lv11) quad_d = QP_MDONE;
      end
      QP_PDONE: begin
        step_d = StepUp;
        quad_d = QP_DETENT;
      end
      QP_MDONE: begin
        step_d = StepDown;
        quad_d = QP_DETENT;
      end
      default: begin
        quad_d = (lv == Lv11) ? QP_DETENT : QP_IDLE;
      end
    endcase
  end

  // Button debouncer and press classification
  always_comb begin
    btn_d       = btn_q;
    deb_cnt_d   = deb_cnt_q;
    held_d      = held_q;
    held_flag_d = held_flag_q;
    short_d     = 1'b0;
    unique case (btn_q)
      BP_IDLE: begin
        if (!in_i.switch_level) begin
          btn_d     = BP_DEBPRS;
          deb_cnt_d = '0;
        end
      end
      BP_DEBPRS: begin
        if (!in_i.switch_level) begin
          deb_cnt_d = deb_inc;
          if (deb_inc >= deb_ticks_q) begin
            btn_d       = BP_PRESSED;
            held_flag_d = 1'b1;
            held_d      = '0;
          end
        end else begin
          btn_d = BP_IDLE;
        end
      end
      BP_PRESSED: begin
        if (in_i.switch_level) begin
          btn_d     = BP_DEBREL;
          deb_cnt_d = '0;
        end else if (held_q != '1) begin
          held_d = held_q + 1'b1;
        end
      end
      BP_DEBREL: begin
        if (in_i.switch_level) begin
          deb_cnt_d = deb_inc;
          if (deb_inc >= deb_ticks_q) begin
            btn_d       = BP_IDLE;
            held_flag_d = 1'b0;
            short_d     = (held_ext_q < long_ext);
            held_d      = '0;
          end
        end else begin
          // bounce: back to pressed, no hold tick this sample
          btn_d = BP_PRESSED;
        end
      end
      default: btn_d = BP_IDLE;
    endcase

    long_d      = 1'b0;
    long_sent_d = long_sent_q;
    if (held_flag_d) begin
      if (!long_sent_q && (held_ext_d >= long_ext)) begin
        long_d      = 1'b1;
        long_sent_d = 1'b1;
      end
    end else begin
      long_sent_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q  <= DebounceReset;
      long_ticks_q <= LongPressReset;
      quad_q       <= QP_IDLE;
      btn_q        <= BP_IDLE;
      deb_cnt_q    <= '0;
      held_q       <= '0;
      held_flag_q  <= 1'b0;
      long_sent_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      step_q       <= StepNone;
      short_q      <= 1'b0;
      long_q       <= 1'b0;
      held_out_q   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == RegDebounceTicks) begin
          deb_ticks_q <= cfg_i.data[DebWidth-1:0];
        end else if (cfg_i.index == RegLongPressTicks) begin
          long_ticks_q <= cfg_i.data[LongWidth-1:0];
        end
      end
      if (in_fire) begin
        quad_q      <= quad_d;
        btn_q       <= btn_d;
        deb_cnt_q   <= deb_cnt_d;
        held_q      <= held_d;
        held_flag_q <= held_flag_d;
        long_sent_q <= long_sent_d;
        out_valid_q <= 1'b1;
        // load the result payload with each accepted item
        step_q      <= step_d;
        short_q     <= short_d;
        long_q      <= long_d;
        held_out_q  <= held_flag_d;
      end else if (out_o.ready) begin
        // drop the delivered item
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.move_step   = step_q;
  assign out_o.short_press = short_q;
  assign out_o.long_press  = long_q;
  assign out_o.button_held = held_out_q;

endmodule : rotary_encoder_button_decoder
`default_nettype wire
